FILE: hdl/ket_pkg.sv
// ----------------------------------------------------------------------------
// ket_pkg
// Shared widths, operation codes and transfer types of the elapsed timer table.
// ----------------------------------------------------------------------------
package ket_pkg;

	localparam int unsigned FUNC_W         = 2;
	localparam int unsigned TS_W           = 64;
	localparam int unsigned ID_W           = 5;
	localparam int unsigned NUM_STATES_DEF = 32;
	localparam int unsigned CMDQ_DEPTH     = 2;
	localparam int unsigned RESQ_DEPTH     = 2;

	localparam logic [FUNC_W-1:0] FN_START = 2'd0;
	localparam logic [FUNC_W-1:0] FN_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_STOP  = 2'd2;
	localparam logic [FUNC_W-1:0] FN_SWEEP = 2'd3;

	localparam logic KIND_REPLY = 1'b0;
	localparam logic KIND_SWEEP = 1'b1;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [TS_W-1:0]   ts;
		logic [ID_W-1:0]   id;
		logic              in_table;
	} cmd_t;

	typedef struct packed {
		logic              kind;
		logic              found;
		logic [ID_W-1:0]   slot_id;
		logic [TS_W-1:0]   elapsed;
		logic              last;
	} res_t;

endpackage

FILE: hdl/ket_front.sv
// ----------------------------------------------------------------------------
// ket_front
// Accepts requests, flags ids outside the table and queues them for the back.
// ----------------------------------------------------------------------------
module ket_front
	import ket_pkg::*;
#(
	parameter int unsigned NUM_STATES = NUM_STATES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [FUNC_W-1:0] func,
	input  logic [TS_W-1:0]   timestamp,
	input  logic [ID_W-1:0]   state_id,
	output logic              cmd_valid,
	output cmd_t              cmd,
	input  logic              cmd_pop
);

	localparam int unsigned PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t             entry_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	cmd_t             cmd_in;
	logic             wr_en;
	logic             rd_en;

	always_comb begin
		cmd_in.func     = func;
		cmd_in.ts       = timestamp;
		cmd_in.id       = state_id;
		cmd_in.in_table = (32'(state_id) < NUM_STATES);
	end

	assign full      = (cnt_q == CNT_W'(CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = entry_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/ket_back.sv
// ----------------------------------------------------------------------------
// ket_back
// Executes queued requests against the running bits and the start time memory.
// ----------------------------------------------------------------------------
module ket_back
	import ket_pkg::*;
#(
	parameter int unsigned NUM_STATES = NUM_STATES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic res_push,
	output res_t res_d,
	input  logic res_full
);

	localparam int unsigned IDX_W = $clog2(NUM_STATES);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RD     = 3'd1;
	localparam logic [2:0] ST_SW_RD  = 3'd2;
	localparam logic [2:0] ST_SW_EX  = 3'd3;
	localparam logic [2:0] ST_SW_END = 3'd4;

	logic [TS_W-1:0]       mem_q [NUM_STATES];
	logic [TS_W-1:0]       rd_q;
	logic [NUM_STATES-1:0] run_q;
	logic [2:0]            state_q;
	logic [IDX_W-1:0]      cnt_q;
	cmd_t                  cur_q;
	logic                  held_v_q;
	logic [IDX_W-1:0]      held_id_q;
	logic [TS_W-1:0]       held_el_q;

	logic [IDX_W-1:0] cmd_idx;
	logic [IDX_W-1:0] cur_idx;
	logic             hit;
	logic [TS_W-1:0]  elapsed_c;
	logic             sw_nz;
	logic             sw_stall;
	logic             cnt_end;
	logic             mem_we;
	logic             mem_re;
	logic [IDX_W-1:0] mem_waddr;
	logic [IDX_W-1:0] mem_raddr;
	logic [TS_W-1:0]  mem_wdata;

	assign cmd_idx   = IDX_W'(cmd.id);
	assign cur_idx   = IDX_W'(cur_q.id);
	assign hit       = cmd.in_table && run_q[cmd_idx];
	assign elapsed_c = cur_q.ts - rd_q;
	assign sw_nz     = (elapsed_c != '0);
	assign sw_stall  = sw_nz && held_v_q && res_full;
	assign cnt_end   = (cnt_q == IDX_W'(NUM_STATES - 1));

	always_comb begin
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		res_d     = '0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = cnt_q;
		mem_raddr = cnt_q;
		mem_wdata = cur_q.ts;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.func)
						FN_START: begin
							cmd_pop   = 1'b1;
							mem_we    = cmd.in_table && !run_q[cmd_idx];
							mem_waddr = cmd_idx;
							mem_wdata = cmd.ts;
						end
						FN_READ, FN_STOP: begin
							if (hit) begin
								cmd_pop   = 1'b1;
								mem_re    = 1'b1;
								mem_raddr = cmd_idx;
							end else if (!res_full) begin
								cmd_pop       = 1'b1;
								res_push      = 1'b1;
								res_d.kind    = KIND_REPLY;
								res_d.found   = 1'b0;
								res_d.slot_id = cmd.id;
								res_d.elapsed = '0;
								res_d.last    = 1'b1;
							end
						end
						FN_SWEEP: begin
							cmd_pop = 1'b1;
						end
					endcase
				end
			end
			ST_RD: begin
				if (!res_full) begin
					res_push      = 1'b1;
					res_d.kind    = KIND_REPLY;
					res_d.found   = 1'b1;
					res_d.slot_id = cur_q.id;
					res_d.elapsed = elapsed_c;
					res_d.last    = 1'b1;
				end
			end
			ST_SW_RD: begin
				mem_re = run_q[cnt_q];
			end
			ST_SW_EX: begin
				if (!sw_stall) begin
					mem_we = 1'b1;
					if (sw_nz && held_v_q) begin
						res_push      = 1'b1;
						res_d.kind    = KIND_SWEEP;
						res_d.found   = 1'b1;
						res_d.slot_id = ID_W'(held_id_q);
						res_d.elapsed = held_el_q;
						res_d.last    = 1'b0;
					end
				end
			end
			ST_SW_END: begin
				if (held_v_q && !res_full) begin
					res_push      = 1'b1;
					res_d.kind    = KIND_SWEEP;
					res_d.found   = 1'b1;
					res_d.slot_id = ID_W'(held_id_q);
					res_d.elapsed = held_el_q;
					res_d.last    = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_q <= mem_q[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		if (state_q == ST_SW_EX && !sw_stall && sw_nz) begin
			held_id_q <= cnt_q;
			held_el_q <= elapsed_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			run_q    <= '0;
			held_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.func)
							FN_START: begin
								if (cmd.in_table) begin
									run_q[cmd_idx] <= 1'b1;
								end
							end
							FN_READ, FN_STOP: begin
								if (hit) begin
									state_q <= ST_RD;
								end
							end
							FN_SWEEP: begin
								state_q  <= ST_SW_RD;
								cnt_q    <= '0;
								held_v_q <= 1'b0;
							end
						endcase
					end
				end
				ST_RD: begin
					if (!res_full) begin
						if (cur_q.func == FN_STOP) begin
							run_q[cur_idx] <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SW_RD: begin
					if (run_q[cnt_q]) begin
						state_q <= ST_SW_EX;
					end else if (cnt_end) begin
						state_q <= ST_SW_END;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SW_EX: begin
					if (!sw_stall) begin
						if (sw_nz) begin
							held_v_q <= 1'b1;
						end
						if (cnt_end) begin
							state_q <= ST_SW_END;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= ST_SW_RD;
						end
					end
				end
				ST_SW_END: begin
					if (!held_v_q || !res_full) begin
						held_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/ket_resq.sv
// ----------------------------------------------------------------------------
// ket_resq
// Result queue between the execution side and the result ports.
// ----------------------------------------------------------------------------
module ket_resq
	import ket_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic res_push,
	input  res_t res_d,
	output logic res_full,
	input  logic pop,
	output logic empty,
	output res_t res_q
);

	localparam int unsigned PTR_W = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(RESQ_DEPTH + 1);

	res_t             entry_q [RESQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             wr_en;
	logic             rd_en;

	assign res_full = (cnt_q == CNT_W'(RESQ_DEPTH));
	assign empty    = (cnt_q == '0);
	assign res_q    = entry_q[rd_ptr_q];
	assign wr_en    = res_push && !res_full;
	assign rd_en    = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(RESQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(RESQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/keyed_elapsed_timer_table_top.sv
// ----------------------------------------------------------------------------
// keyed_elapsed_timer_table_top
// Table of start timestamps keyed by state id, with read, stop and sweep.
// ----------------------------------------------------------------------------
//  channel   | handshake        | payload
//  ----------+------------------+--------------------------------------------
//  request   | push / full      | func, timestamp, state_id
//  result    | pop / empty      | kind, found, slot_id, elapsed, last
//
//  Requests enter a two-entry queue, one transfer per cycle while not full.
//  Start and a read of an idle slot finish in the idle state; a read of a
//  running slot reads the start time memory, then subtracts in ST_RD.
//  A sweep visits every slot in turn and rewrites the start time of each
//  running slot. Reset clears the running bits only; no clearing pass.
//  A full result queue stalls result pushes; the request queue keeps accepting.
// ----------------------------------------------------------------------------
module keyed_elapsed_timer_table_top
	import ket_pkg::*;
#(
	parameter int unsigned NUM_STATES = NUM_STATES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [FUNC_W-1:0] func,
	input  logic [TS_W-1:0]   timestamp,
	input  logic [ID_W-1:0]   state_id,
	output logic              empty,
	input  logic              pop,
	output logic              kind,
	output logic              found,
	output logic [ID_W-1:0]   slot_id,
	output logic [TS_W-1:0]   elapsed,
	output logic              last
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	logic res_push;
	res_t res_d;
	logic res_full;
	res_t res_q;

	ket_front #(
		.NUM_STATES(NUM_STATES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.timestamp (timestamp),
		.state_id  (state_id),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	ket_back #(
		.NUM_STATES(NUM_STATES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res_d     (res_d),
		.res_full  (res_full)
	);

	ket_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_d    (res_d),
		.res_full (res_full),
		.pop      (pop),
		.empty    (empty),
		.res_q    (res_q)
	);

	assign kind    = res_q.kind;
	assign found   = res_q.found;
	assign slot_id = res_q.slot_id;
	assign elapsed = res_q.elapsed;
	assign last    = res_q.last;

	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result written into a full queue");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("request taken from an empty queue");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !found) |-> (elapsed == '0 && kind == KIND_REPLY && last))
		else $error("miss reply with nonzero elapsed time");

	a_sweep_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_SWEEP) |-> (found && elapsed != '0))
		else $error("sweep entry without a nonzero elapsed time");

endmodule

FILE: bench/timer_table_check_pkg.sv
// ----------------------------------------------------------------------------
// timer_table_check_pkg
// Expected-result tracking for the keyed elapsed timer table. The class keeps
// its own copy of the start times and running bits, turns every accepted
// request into the replies or sweep entries it must cause, and compares each
// result transfer with the oldest one still owed.
// ----------------------------------------------------------------------------
package timer_table_check_pkg;

	import ket_pkg::*;

	class timer_table_scoreboard;

		bit [TS_W-1:0] start_at[NUM_STATES_DEF];
		bit            running[NUM_STATES_DEF];
		res_t          owed[$];
		int unsigned   mismatches;
		int unsigned   delivered;

		function new();
			mismatches = 0;
			delivered  = 0;
			foreach (running[i]) begin
				running[i]  = 1'b0;
				start_at[i] = '0;
			end
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			mismatches++;
		endtask

		function int unsigned outstanding();
			return owed.size();
		endfunction

		function void note_request(logic [FUNC_W-1:0] op, logic [TS_W-1:0] ts,
		                           logic [ID_W-1:0] id);
			res_t r;
			res_t sweep_hits[$];
			bit   hit;
			hit = (id < NUM_STATES_DEF) && running[id];
			r   = '0;
			case (op)
				FN_START: begin
					if (id < NUM_STATES_DEF && !running[id]) begin
						start_at[id] = ts;
						running[id]  = 1'b1;
					end
				end
				FN_READ, FN_STOP: begin
					r.kind    = KIND_REPLY;
					r.found   = hit;
					r.slot_id = id;
					r.elapsed = hit ? ts - start_at[id] : '0;
					r.last    = 1'b1;
					owed.push_back(r);
					if (hit && op == FN_STOP)
						running[id] = 1'b0;
				end
				default: begin
					for (int i = 0; i < NUM_STATES_DEF; i++) begin
						if (running[i]) begin
							if (ts != start_at[i]) begin
								r.kind    = KIND_SWEEP;
								r.found   = 1'b1;
								r.slot_id = ID_W'(i);
								r.elapsed = ts - start_at[i];
								r.last    = 1'b0;
								sweep_hits.push_back(r);
							end
							start_at[i] = ts;
						end
					end
					if (sweep_hits.size() != 0)
						sweep_hits[sweep_hits.size() - 1].last = 1'b1;
					foreach (sweep_hits[k])
						owed.push_back(sweep_hits[k]);
				end
			endcase
		endfunction

		task check_result(res_t got);
			res_t want;
			if (owed.size() == 0) begin
				report($sformatf("unexpected result kind %0d slot %0d elapsed %h",
					got.kind, got.slot_id, got.elapsed));
				return;
			end
			want = owed.pop_front();
			delivered++;
			if (got.kind !== want.kind)
				report($sformatf("slot %0d kind %0d, want %0d",
					want.slot_id, got.kind, want.kind));
			if (got.found !== want.found)
				report($sformatf("slot %0d found %0d, want %0d",
					want.slot_id, got.found, want.found));
			if (got.slot_id !== want.slot_id)
				report($sformatf("slot_id %0d, want %0d", got.slot_id, want.slot_id));
			if (got.elapsed !== want.elapsed)
				report($sformatf("slot %0d elapsed %h, want %h",
					want.slot_id, got.elapsed, want.elapsed));
			if (got.last !== want.last)
				report($sformatf("slot %0d last %0d, want %0d",
					want.slot_id, got.last, want.last));
		endtask

	endclass

endpackage

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the keyed elapsed timer table. Directed requests cover the
// timestamp extremes, wraparound, restart of a running slot, reads of idle
// slots and sweeps with and without entries; then random requests on a mostly
// rising time base. Both sides idle at random, and the result side holds off
// once for a long stretch so that both queues fill and push is refused.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import ket_pkg::*;
	import timer_table_check_pkg::*;

	localparam int unsigned RANDOM_REQUESTS = 160;
	localparam int unsigned QUIET_LIMIT     = 20000;
	localparam int unsigned HOLD_CYCLES     = 400;
	localparam int unsigned TAIL_CYCLES     = 100;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              push      = 1'b0;
	logic              pop       = 1'b0;
	logic [FUNC_W-1:0] func      = FN_START;
	logic [TS_W-1:0]   timestamp = '0;
	logic [ID_W-1:0]   state_id  = '0;
	logic              full;
	logic              empty;
	logic              kind;
	logic              found;
	logic [ID_W-1:0]   slot_id;
	logic [TS_W-1:0]   elapsed;
	logic              last;

	timer_table_scoreboard sb = new();

	bit [TS_W-1:0] now;
	bit            calm_tx;
	bit            calm_rx;

	keyed_elapsed_timer_table_top #(
		.NUM_STATES(NUM_STATES_DEF)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.timestamp (timestamp),
		.state_id  (state_id),
		.empty     (empty),
		.pop       (pop),
		.kind      (kind),
		.found     (found),
		.slot_id   (slot_id),
		.elapsed   (elapsed),
		.last      (last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int unsigned gap_len(bit calm);
		int unsigned pick;
		if (calm)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 65)
			return 0;
		if (pick < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_request(logic [FUNC_W-1:0] op, logic [TS_W-1:0] ts,
	                            logic [ID_W-1:0] id);
		int unsigned gap;
		if ($urandom_range(0, 24) == 0)
			calm_tx = !calm_tx;
		gap = gap_len(calm_tx);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push      <= 1'b1;
		func      <= op;
		timestamp <= ts;
		state_id  <= id;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_request(op, ts, id);
	endtask

	task automatic random_request();
		logic [FUNC_W-1:0] op;
		logic [ID_W-1:0]   id;
		int unsigned       pick;
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			if ($urandom_range(0, 9) != 0)
				now = now + TS_W'($urandom_range(1, 1000));
		end else if (pick < 90) begin
			now = now + {32'd0, $urandom()};
		end else begin
			now = {$urandom(), $urandom()};
		end
		pick = $urandom_range(0, 99);
		if (pick < 40)
			op = FN_START;
		else if (pick < 62)
			op = FN_READ;
		else if (pick < 87)
			op = FN_STOP;
		else
			op = FN_SWEEP;
		if ($urandom_range(0, 1) == 0)
			id = ID_W'($urandom_range(0, 7));
		else
			id = ID_W'($urandom());
		send_request(op, now, id);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(FN_START, 64'd0, 5'd0);
		send_request(FN_READ, '1, 5'd0);
		send_request(FN_START, 64'd5, 5'd0);
		send_request(FN_READ, 64'd7, 5'd0);
		send_request(FN_STOP, 64'h8000_0000_0000_0000, 5'd0);
		send_request(FN_READ, 64'd9, 5'd0);
		send_request(FN_STOP, 64'd9, 5'd0);
		send_request(FN_READ, 64'd9, 5'd31);
		send_request(FN_START, '1, 5'd31);
		send_request(FN_READ, 64'd2, 5'd31);
		send_request(FN_SWEEP, '1, 5'd13);
		send_request(FN_START, 64'd100, 5'd21);
		send_request(FN_START, 64'h5555_5555_5555_5555, 5'd10);
		send_request(FN_SWEEP, 64'hAAAA_AAAA_AAAA_AAAA, 5'd0);
		send_request(FN_SWEEP, 64'hAAAA_AAAA_AAAA_AAAA, 5'd31);
		send_request(FN_STOP, 64'hAAAA_AAAA_AAAA_ABCD, 5'd10);
		send_request(FN_STOP, 64'hAAAA_AAAA_AAAA_ABCE, 5'd21);
		send_request(FN_STOP, 64'h0000_0000_0000_0001, 5'd31);
		send_request(FN_SWEEP, 64'd12345, 5'd7);
		send_request(FN_READ, 64'd12346, 5'd21);

		now = 64'd1000;
		repeat (RANDOM_REQUESTS) random_request();
		push <= 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// result side; one long hold-off once traffic is flowing
	initial begin
		int unsigned gap;
		bit          held;
		res_t        got;
		held = 1'b0;
		wait (arst_n);
		forever begin
			if (!held && sb.delivered >= 40) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if ($urandom_range(0, 39) == 0)
				calm_rx = !calm_rx;
			gap = gap_len(calm_rx);
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			if (!empty) begin
				got.kind    = kind;
				got.found   = found;
				got.slot_id = slot_id;
				got.elapsed = elapsed;
				got.last    = last;
				sb.check_result(got);
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: keyed_elapsed_timer_table_top.f
hdl/ket_pkg.sv
hdl/ket_front.sv
hdl/ket_back.sv
hdl/ket_resq.sv
hdl/keyed_elapsed_timer_table_top.sv
bench/timer_table_check_pkg.sv
bench/tb_top.sv
